>>> rtl/telemetry_frame_validator_unit_defines.svh
// ----------------------------------------------------------------------------
// telemetry frame validator assertion macros
// concurrent assertion helpers, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef TELEMETRY_FRAME_VALIDATOR_UNIT_DEFINES_SVH
`define TELEMETRY_FRAME_VALIDATOR_UNIT_DEFINES_SVH

`ifndef SYNTH
`define TFV_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("tfv assertion failed");
`define TFV_ASSERT_NEVER(label, expr) \
  `TFV_ASSERT(label, !(expr))
`else
`define TFV_ASSERT(label, prop)
`define TFV_ASSERT_NEVER(label, expr)
`endif

`endif

>>> rtl/tfv_pkg.sv
// ----------------------------------------------------------------------------
// tfv package
// types and constants shared by the telemetry frame validator
// ----------------------------------------------------------------------------
package tfv_pkg;

  localparam int unsigned NUM_TYPES = 4;

  localparam logic [7:0]  MAGIC_FIRST      = 8'h54;
  localparam logic [7:0]  MAGIC_SECOND     = 8'h4D;
  localparam logic [15:0] CRC_INIT         = 16'hFFFF;
  localparam logic [15:0] CRC_POLY         = 16'h1021;
  localparam logic [8:0]  COUNT_MAX        = 9'd511;
  localparam logic [8:0]  TRAILER_BYTES    = 9'd2;
  localparam logic [8:0]  FRAME_OVERHEAD   = 9'd7;
  localparam logic [2:0]  HEADER_BYTES     = 3'd5;
  localparam logic [31:0] TYPE_CODES_RESET = 32'h0302_0100;

  localparam logic [8:0] POS_MAGIC0  = 9'd0;
  localparam logic [8:0] POS_MAGIC1  = 9'd1;
  localparam logic [8:0] POS_VERSION = 9'd2;
  localparam logic [8:0] POS_TYPE    = 9'd3;
  localparam logic [8:0] POS_LENGTH  = 9'd4;

  typedef enum logic [2:0] {
    CFG_VERSION    = 3'd0,
    CFG_TYPE_CODES = 3'd1,
    CFG_FAST_LEN   = 3'd2,
    CFG_SLOW_LEN   = 3'd3,
    CFG_EVENT_LEN  = 3'd4,
    CFG_SENSOR_LEN = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0]                  version;
    logic [31:0]                 type_codes;
    logic [NUM_TYPES-1:0][7:0]   body_len;
  } cfg_t;

  typedef struct packed {
    logic       frame_valid;
    logic [7:0] packet_kind;
    logic [2:0] payload_offset;
    logic [7:0] payload_length;
  } res_t;

  function automatic logic [15:0] crc_absorb(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

>>> rtl/tfv_ifs.sv
// ----------------------------------------------------------------------------
// tfv channel interfaces
// byte input, result output and register write channels
// ----------------------------------------------------------------------------
interface tfv_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_end;

  modport source (output valid, rx_byte, frame_end, input ready);
  modport sink   (input valid, rx_byte, frame_end, output ready);
endinterface

interface tfv_res_if;
  logic       valid;
  logic       ready;
  logic       frame_valid;
  logic [7:0] packet_kind;
  logic [2:0] payload_offset;
  logic [7:0] payload_length;

  modport source (output valid, frame_valid, packet_kind, payload_offset, payload_length,
                  input ready);
  modport sink   (input valid, frame_valid, packet_kind, payload_offset, payload_length,
                  output ready);
endinterface

interface tfv_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/tfv_frame_core.sv
// ----------------------------------------------------------------------------
// tfv frame core
// per-frame header, length and crc-16 checks, one byte per step
// ----------------------------------------------------------------------------
module tfv_frame_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  tfv_pkg::cfg_t cfg_i,
  input  logic          step_i,
  input  logic [7:0]    byte_i,
  input  logic          end_i,
  output tfv_pkg::res_t result_o
);
  import tfv_pkg::*;

  logic [15:0] crc_q, crc_d;
  logic [8:0]  cnt_q, cnt_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  len_q, len_d;
  logic        good_q, good_d;
  logic [7:0]  tail0_q, tail1_q;

  logic        found;
  logic [7:0]  need;
  logic [15:0] rx_crc;
  logic        ok;

  // first matching code wins
  always_comb begin
    found = 1'b0;
    need  = '0;
    for (int i = 0; i < NUM_TYPES; i++) begin
      if (!found && cfg_i.type_codes[8*i +: 8] == type_q) begin
        found = 1'b1;
        need  = cfg_i.body_len[i];
      end
    end
  end

  always_comb begin
    good_d = good_q;
    type_d = type_q;
    len_d  = len_q;
    case (cnt_q)
      POS_MAGIC0: begin
        if (byte_i != MAGIC_FIRST) good_d = 1'b0;
      end
      POS_MAGIC1: begin
        if (byte_i != MAGIC_SECOND) good_d = 1'b0;
      end
      POS_VERSION: begin
        if (byte_i != cfg_i.version) good_d = 1'b0;
      end
      POS_TYPE: begin
        type_d = byte_i;
      end
      POS_LENGTH: begin
        len_d = byte_i;
        if (!found || need != byte_i) good_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // the two newest bytes may be the trailer, so the crc lags by two
  assign crc_d  = (cnt_q >= TRAILER_BYTES) ? crc_absorb(crc_q, tail1_q) : crc_q;
  assign cnt_d  = (cnt_q != COUNT_MAX) ? cnt_q + 9'd1 : cnt_q;
  assign rx_crc = {byte_i, tail0_q};
  assign ok     = good_d && (cnt_d == FRAME_OVERHEAD + {1'b0, len_d}) && (rx_crc == crc_d);

  always_comb begin
    result_o.frame_valid    = ok;
    result_o.packet_kind    = ok ? type_d : '0;
    result_o.payload_offset = ok ? HEADER_BYTES : '0;
    result_o.payload_length = ok ? len_d : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q   <= CRC_INIT;
      cnt_q   <= '0;
      type_q  <= '0;
      len_q   <= '0;
      good_q  <= 1'b1;
      tail0_q <= '0;
      tail1_q <= '0;
    end else if (step_i) begin
      if (end_i) begin
        crc_q   <= CRC_INIT;
        cnt_q   <= '0;
        type_q  <= '0;
        len_q   <= '0;
        good_q  <= 1'b1;
        tail0_q <= '0;
        tail1_q <= '0;
      end else begin
        crc_q   <= crc_d;
        cnt_q   <= cnt_d;
        type_q  <= type_d;
        len_q   <= len_d;
        good_q  <= good_d;
        tail0_q <= byte_i;
        tail1_q <= tail0_q;
      end
    end
  end

endmodule

>>> rtl/telemetry_frame_validator_unit.sv
// ----------------------------------------------------------------------------
// telemetry frame validator unit
// checks framed telemetry bytes: magic, version, type, length and crc-16
//
// channels: rx_i takes one frame byte per transfer with frame_end on the
// last byte; res_o gives one result per frame, on its last byte; cfg_i
// writes the six registers by index, accepted in every cycle.
// path: a byte is captured in the input register and checked from there;
// its result, if any, is loaded into the result register when the byte
// leaves the input register, and is offered on res_o from there.
// throughput: one byte per cycle, set by the crc byte update, save in a stall.
// reset: registers take their reset values, the frame state is cleared and
// both registers are empty.
// stall: a result waiting on res_o holds; bytes that produce no result keep
// flowing, and a frame's last byte waits in the input register until the
// result register frees, with rx_i.ready low while it waits.
// ----------------------------------------------------------------------------
`include "telemetry_frame_validator_unit_defines.svh"

module telemetry_frame_validator_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  tfv_rx_if.sink     rx_i,
  tfv_res_if.source  res_o,
  tfv_cfg_if.sink    cfg_i
);
  import tfv_pkg::*;

  cfg_t       cfg_q;
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_end_q;
  logic       advance;
  logic       out_valid_q;
  res_t       out_q;
  res_t       core_res;

  // register writes, unknown indexes ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.version    <= '0;
      cfg_q.type_codes <= TYPE_CODES_RESET;
      cfg_q.body_len   <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_VERSION:    cfg_q.version     <= cfg_i.data[7:0];
        CFG_TYPE_CODES: cfg_q.type_codes  <= cfg_i.data;
        CFG_FAST_LEN:   cfg_q.body_len[0] <= cfg_i.data[7:0];
        CFG_SLOW_LEN:   cfg_q.body_len[1] <= cfg_i.data[7:0];
        CFG_EVENT_LEN:  cfg_q.body_len[2] <= cfg_i.data[7:0];
        CFG_SENSOR_LEN: cfg_q.body_len[3] <= cfg_i.data[7:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_i.ready = 1'b1;

  assign advance    = in_valid_q && (!in_end_q || !out_valid_q || res_o.ready);
  assign rx_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.ready && rx_i.valid) begin
      in_byte_q <= rx_i.rx_byte;
      in_end_q  <= rx_i.frame_end;
    end
  end

  tfv_frame_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .step_i   (advance),
    .byte_i   (in_byte_q),
    .end_i    (in_end_q),
    .result_o (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && in_end_q) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_end_q) begin
      out_q <= core_res;
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.frame_valid    = out_q.frame_valid;
  assign res_o.packet_kind    = out_q.packet_kind;
  assign res_o.payload_offset = out_q.payload_offset;
  assign res_o.payload_length = out_q.payload_length;

  `TFV_ASSERT(a_reject_zeroed, out_valid_q && !out_q.frame_valid |-> out_q.packet_kind == '0 && out_q.payload_offset == '0 && out_q.payload_length == '0)
  `TFV_ASSERT(a_accept_offset, out_valid_q && out_q.frame_valid |-> out_q.payload_offset == HEADER_BYTES)
  `TFV_ASSERT(a_mid_frame_silent, advance && !in_end_q |=> !$rose(out_valid_q))
  `TFV_ASSERT(a_input_held, in_valid_q && !advance |=> in_valid_q && $stable(in_byte_q))
  `TFV_ASSERT_NEVER(a_no_result_overrun, advance && in_end_q && out_valid_q && !res_o.ready)

endmodule
